### sv/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the symbol table unit: sizes, action and
// status codes, sequencer states and the store port structures.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int DEPTH       = 32;
	localparam int LABEL_BYTES = 8;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W      = $clog2(DEPTH + 1);

	localparam logic [63:0] TEXT_MASK = (LABEL_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (LABEL_BYTES * 8)) - 64'd1);

	localparam logic [2:0] ACT_INSERT    = 3'd0;
	localparam logic [2:0] ACT_SEARCH    = 3'd1;
	localparam logic [2:0] ACT_MOD_LABEL = 3'd2;
	localparam logic [2:0] ACT_MOD_ADDR  = 3'd3;
	localparam logic [2:0] ACT_MOD_BOTH  = 3'd4;
	localparam logic [2:0] ACT_READ      = 3'd5;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_DUPLICATE = 3'd1;
	localparam logic [2:0] STS_NOT_FOUND = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_RANGE     = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_label_en;
		logic              wr_symbol_en;
		logic              wr_address_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [63:0]       wr_label;
		logic [63:0]       wr_symbol;
		logic [15:0]       wr_address;
	} store_req_t;

	typedef struct packed {
		logic [63:0] label;
		logic [63:0] symbol;
		logic [15:0] address;
	} store_data_t;

	typedef struct packed {
		logic        load;
		logic [2:0]  status;
		logic        found;
		logic [63:0] label;
		logic [63:0] symbol;
		logic [15:0] address;
		logic [5:0]  entry_count;
	} result_t;

endpackage

### sv/stc_store.sv
// ----------------------------------------------------------------------------
// stc_store
// Entry storage: label, symbol and address memories with one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module stc_store (
	input  logic                clk,
	input  stc_pkg::store_req_t req,
	output stc_pkg::store_data_t rdata
);

	logic [63:0] label_mem   [stc_pkg::DEPTH];
	logic [63:0] symbol_mem  [stc_pkg::DEPTH];
	logic [15:0] address_mem [stc_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_label_en) begin
			label_mem[req.wr_addr] <= req.wr_label;
		end
		if (req.wr_symbol_en) begin
			symbol_mem[req.wr_addr] <= req.wr_symbol;
		end
		if (req.wr_address_en) begin
			address_mem[req.wr_addr] <= req.wr_address;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata.label   <= label_mem[req.rd_addr];
			rdata.symbol  <= symbol_mem[req.rd_addr];
			rdata.address <= address_mem[req.rd_addr];
		end
	end

endmodule

### sv/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer and shared label comparator: walks the stored entries one a
// cycle, rewrites matches on modify, appends on insert and builds the result.
// ----------------------------------------------------------------------------
module stc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           action,
	input  logic [63:0]          key_label,
	input  logic [63:0]          new_label,
	input  logic [63:0]          symbol_in,
	input  logic [15:0]          address_in,
	input  logic [4:0]           entry_index,
	input  logic                 res_free,
	output stc_pkg::store_req_t  req,
	input  stc_pkg::store_data_t rdata,
	output stc_pkg::result_t     res
);

	stc_pkg::state_t state_q, state_d;

	logic [2:0]                  action_q;
	logic [63:0]                 key_q;
	logic [63:0]                 nlab_q;
	logic [63:0]                 sym_q;
	logic [15:0]                 addr_q;
	logic [4:0]                  idx_q;
	logic [stc_pkg::FILL_W-1:0]  ptr_q;
	logic [stc_pkg::FILL_W-1:0]  fill_q;
	logic                        hit_q;
	logic                        valid_s1;
	logic [stc_pkg::ADDR_W-1:0]  ptr_s1;

	logic accept;
	logic issue;
	logic match;
	logic in_range;
	logic is_modify;
	logic is_scan_act;
	logic not_full;
	logic fire;
	logic do_insert;

	assign accept      = in_valid && in_ready;
	assign issue       = (state_q == stc_pkg::ST_SCAN) && (ptr_q < fill_q);
	// one comparator serves every entry of the walk
	assign match       = valid_s1 && (rdata.label == key_q);
	assign in_range    = 32'(idx_q) < 32'(fill_q);
	assign is_modify   = action_q inside {stc_pkg::ACT_MOD_LABEL, stc_pkg::ACT_MOD_ADDR,
		stc_pkg::ACT_MOD_BOTH};
	assign is_scan_act = is_modify || (action_q == stc_pkg::ACT_INSERT) ||
		(action_q == stc_pkg::ACT_SEARCH);
	assign not_full    = 32'(fill_q) < stc_pkg::DEPTH;
	assign fire        = (state_q == stc_pkg::ST_FINISH) && res_free;
	assign do_insert   = fire && (action_q == stc_pkg::ACT_INSERT) && !hit_q && not_full;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stc_pkg::ST_IDLE: begin
				if (accept) begin
					if (action inside {[stc_pkg::ACT_INSERT:stc_pkg::ACT_MOD_BOTH]}) begin
						state_d = stc_pkg::ST_SCAN;
					end else if (action == stc_pkg::ACT_READ) begin
						state_d = stc_pkg::ST_READ;
					end else begin
						state_d = stc_pkg::ST_FINISH;
					end
				end
			end
			stc_pkg::ST_SCAN: begin
				if (!issue) begin
					state_d = stc_pkg::ST_FINISH;
				end
			end
			stc_pkg::ST_READ: begin
				state_d = stc_pkg::ST_FINISH;
			end
			stc_pkg::ST_FINISH: begin
				if (res_free) begin
					state_d = stc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stc_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == stc_pkg::ST_IDLE);

		req               = '0;
		req.wr_label      = nlab_q;
		req.wr_symbol     = sym_q;
		req.wr_address    = addr_q;
		req.wr_addr       = ptr_s1;
		if (issue) begin
			req.rd_en   = 1'b1;
			req.rd_addr = ptr_q[stc_pkg::ADDR_W-1:0];
		end else if (state_q == stc_pkg::ST_READ) begin
			req.rd_en   = in_range;
			req.rd_addr = stc_pkg::ADDR_W'(idx_q);
		end
		if (do_insert) begin
			req.wr_label_en   = 1'b1;
			req.wr_symbol_en  = 1'b1;
			req.wr_address_en = 1'b1;
			req.wr_addr       = fill_q[stc_pkg::ADDR_W-1:0];
			req.wr_label      = key_q;
		end else if (match && is_modify) begin
			req.wr_label_en   = (action_q != stc_pkg::ACT_MOD_ADDR);
			req.wr_address_en = (action_q != stc_pkg::ACT_MOD_LABEL);
		end

		res             = '0;
		res.load        = fire;
		res.found       = hit_q && is_scan_act;
		res.entry_count = do_insert ? 6'(fill_q + 1'b1) : 6'(fill_q);
		case (action_q)
			stc_pkg::ACT_INSERT: begin
				if (hit_q) begin
					res.status = stc_pkg::STS_DUPLICATE;
				end else if (!not_full) begin
					res.status = stc_pkg::STS_FULL;
				end else begin
					res.status = stc_pkg::STS_OK;
				end
			end
			stc_pkg::ACT_SEARCH, stc_pkg::ACT_MOD_LABEL, stc_pkg::ACT_MOD_ADDR,
			stc_pkg::ACT_MOD_BOTH: begin
				res.status = hit_q ? stc_pkg::STS_OK : stc_pkg::STS_NOT_FOUND;
			end
			stc_pkg::ACT_READ: begin
				if (in_range) begin
					res.status  = stc_pkg::STS_OK;
					res.label   = rdata.label;
					res.symbol  = rdata.symbol;
					res.address = rdata.address;
				end else begin
					res.status = stc_pkg::STS_RANGE;
				end
			end
			default: begin
				res.status = stc_pkg::STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stc_pkg::ST_IDLE;
			fill_q   <= '0;
			hit_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (accept) begin
				hit_q <= 1'b0;
			end else if (match) begin
				hit_q <= 1'b1;
			end
			if (do_insert) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= key_label & stc_pkg::TEXT_MASK;
			nlab_q   <= new_label & stc_pkg::TEXT_MASK;
			sym_q    <= symbol_in & stc_pkg::TEXT_MASK;
			addr_q   <= address_in;
			idx_q    <= entry_index;
			ptr_q    <= '0;
		end else if (issue) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (issue) begin
			ptr_s1 <= ptr_q[stc_pkg::ADDR_W-1:0];
		end
	end

endmodule

### sv/symbol_table_cam_unit.sv
// ----------------------------------------------------------------------------
// symbol_table_cam_unit
// Assembler symbol table: insert, search, modify and read of label, symbol
// and address entries held in insertion order.
// ----------------------------------------------------------------------------
// One transfer is taken at a time; in_ready is low until its result has been
// loaded into the output register. Insert, search and the modify actions walk
// the held entries through one label comparator and the single store read
// port, one entry a cycle, and in_ready returns in the cycle in which
// out_valid rises. A read of an entry goes through the store read port and
// the finish state; an unknown action goes straight to the finish state. A
// held-off output register holds the finish state until it is free.
// No clearing pass follows reset.
module symbol_table_cam_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [63:0] key_label,
	input  logic [63:0] new_label,
	input  logic [63:0] symbol_in,
	input  logic [15:0] address_in,
	input  logic [4:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        found,
	output logic [63:0] label_out,
	output logic [63:0] symbol_out,
	output logic [15:0] address_out,
	output logic [5:0]  entry_count
);

	stc_pkg::store_req_t  req;
	stc_pkg::store_data_t rdata;
	stc_pkg::result_t     res;
	logic                 out_valid_q;
	logic                 res_free;

	assign res_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	stc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.key_label   (key_label),
		.new_label   (new_label),
		.symbol_in   (symbol_in),
		.address_in  (address_in),
		.entry_index (entry_index),
		.res_free    (res_free),
		.req         (req),
		.rdata       (rdata),
		.res         (res)
	);

	stc_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			status      <= res.status;
			found       <= res.found;
			label_out   <= res.label;
			symbol_out  <= res.symbol;
			address_out <= res.address;
			entry_count <= res.entry_count;
		end
	end

`ifndef SYNTH
	// busy after each input transfer until the result is built
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an action is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(entry_count) <= stc_pkg::DEPTH)
		else $error("entry count beyond table depth");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status != stc_pkg::STS_NOT_FOUND &&
		status != stc_pkg::STS_RANGE && status != stc_pkg::STS_FULL)
		else $error("label found but status reports a miss");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == stc_pkg::STS_FULL |-> 32'(entry_count) == stc_pkg::DEPTH)
		else $error("table full reported below depth");
`endif

endmodule

### dv/symbol_table_cam_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_table_cam_check
// Watches both channels of the symbol table unit. Keeps its own copy of the
// table, works out the reply for every accepted request, and compares each
// reply that leaves the unit with the oldest reply still awaited.
// ----------------------------------------------------------------------------
module symbol_table_cam_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  action,
	input  logic [63:0] key_label,
	input  logic [63:0] new_label,
	input  logic [63:0] symbol_in,
	input  logic [15:0] address_in,
	input  logic [4:0]  entry_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic        found,
	input  logic [63:0] label_out,
	input  logic [63:0] symbol_out,
	input  logic [15:0] address_out,
	input  logic [5:0]  entry_count,
	output int          mismatch_count,
	output int          replies_pending
);

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [63:0] label;
		logic [63:0] symbol;
		logic [15:0] address;
		logic [5:0]  entry_count;
	} table_reply_t;

	int           held_entries = 0;
	logic [63:0]  held_label   [stc_pkg::DEPTH];
	logic [63:0]  held_symbol  [stc_pkg::DEPTH];
	logic [15:0]  held_address [stc_pkg::DEPTH];
	table_reply_t awaited_replies [$];
	int           fail_total = 0;
	int           awaited_total = 0;

	assign mismatch_count  = fail_total;
	assign replies_pending = awaited_total;

	// applies one request to the local table and returns the reply it earns
	function automatic table_reply_t apply_table_request(input logic [2:0] act,
			input logic [63:0] key_raw, input logic [63:0] nlab_raw,
			input logic [63:0] sym_raw, input logic [15:0] addr,
			input logic [4:0] idx);
		table_reply_t reply;
		logic [63:0]  key;
		logic [63:0]  nlab;
		logic         hit;
		int           i;
		key   = key_raw & stc_pkg::TEXT_MASK;
		nlab  = nlab_raw & stc_pkg::TEXT_MASK;
		reply = '0;
		hit   = 1'b0;
		for (i = 0; i < held_entries; i++)
			if (held_label[i] == key)
				hit = 1'b1;
		if (act <= stc_pkg::ACT_MOD_BOTH)
			reply.found = hit;
		case (act)
		stc_pkg::ACT_INSERT: begin
			if (hit) begin
				reply.status = stc_pkg::STS_DUPLICATE;
			end else if (held_entries >= stc_pkg::DEPTH) begin
				reply.status = stc_pkg::STS_FULL;
			end else begin
				held_label[held_entries]   = key;
				held_symbol[held_entries]  = sym_raw & stc_pkg::TEXT_MASK;
				held_address[held_entries] = addr;
				held_entries++;
			end
		end
		stc_pkg::ACT_SEARCH: begin
			if (!hit)
				reply.status = stc_pkg::STS_NOT_FOUND;
		end
		stc_pkg::ACT_MOD_LABEL, stc_pkg::ACT_MOD_ADDR, stc_pkg::ACT_MOD_BOTH: begin
			if (!hit) begin
				reply.status = stc_pkg::STS_NOT_FOUND;
			end else begin
				// every matching entry is rewritten, duplicates included
				for (i = 0; i < held_entries; i++) begin
					if (held_label[i] == key) begin
						if (act != stc_pkg::ACT_MOD_ADDR)
							held_label[i] = nlab;
						if (act != stc_pkg::ACT_MOD_LABEL)
							held_address[i] = addr;
					end
				end
			end
		end
		stc_pkg::ACT_READ: begin
			if (idx < held_entries) begin
				reply.label   = held_label[idx];
				reply.symbol  = held_symbol[idx];
				reply.address = held_address[idx];
			end else begin
				reply.status = stc_pkg::STS_RANGE;
			end
		end
		default: ;
		endcase
		reply.entry_count = held_entries[5:0];
		return reply;
	endfunction

	always @(posedge clk) begin
		table_reply_t seen;
		table_reply_t wanted;
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_replies.push_back(apply_table_request(action, key_label,
					new_label, symbol_in, address_in, entry_index));
			if (out_valid && out_ready) begin
				seen = {status, found, label_out, symbol_out, address_out, entry_count};
				if (awaited_replies.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: reply with none awaited: status %0d found %0b",
							$realtime, seen.status, seen.found);
				end else begin
					wanted = awaited_replies.pop_front();
					if (seen !== wanted) begin
						fail_total++;
						if (fail_total <= 10) begin
							$display("%0t: reply mismatch", $realtime);
							$display("  expected status %0d found %0b label %h symbol %h addr %h count %0d",
								wanted.status, wanted.found, wanted.label, wanted.symbol,
								wanted.address, wanted.entry_count);
							$display("  actual   status %0d found %0b label %h symbol %h addr %h count %0d",
								seen.status, seen.found, seen.label, seen.symbol,
								seen.address, seen.entry_count);
						end
					end
				end
			end
			awaited_total = awaited_replies.size();
		end
	end

endmodule

### dv/symbol_table_cam_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_table_cam_unit_test
// Drives the symbol table unit with a directed run through every action and
// corner case, then random requests drawn mostly from a small label pool so
// that hits, duplicates and a full table are common. Both sides stall at
// random; the reply checker beside the unit gives the failure count.
// ----------------------------------------------------------------------------
module symbol_table_cam_unit_test;

	// actions the unit does not know
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1525;
	localparam int POOL_SIZE    = 48;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [63:0] key_label;
	logic [63:0] new_label;
	logic [63:0] symbol_in;
	logic [15:0] address_in;
	logic [4:0]  entry_index;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic        found;
	logic [63:0] label_out;
	logic [63:0] symbol_out;
	logic [15:0] address_out;
	logic [5:0]  entry_count;
	int          mismatch_count;
	int          replies_pending;

	int          send_idle_pct = 19;
	int          recv_idle_pct = 69;
	bit          hold_request  = 1'b0;
	logic [63:0] label_pool [POOL_SIZE];

	symbol_table_cam_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.key_label   (key_label),
		.new_label   (new_label),
		.symbol_in   (symbol_in),
		.address_in  (address_in),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found       (found),
		.label_out   (label_out),
		.symbol_out  (symbol_out),
		.address_out (address_out),
		.entry_count (entry_count)
	);

	symbol_table_cam_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.key_label       (key_label),
		.new_label       (new_label),
		.symbol_in       (symbol_in),
		.address_in      (address_in),
		.entry_index     (entry_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.found           (found),
		.label_out       (label_out),
		.symbol_out      (symbol_out),
		.address_out     (address_out),
		.entry_count     (entry_count),
		.mismatch_count  (mismatch_count),
		.replies_pending (replies_pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic offer_request(input logic [2:0] act, input logic [63:0] key,
			input logic [63:0] nlab, input logic [63:0] sym,
			input logic [15:0] addr, input logic [4:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		key_label   <= key;
		new_label   <= nlab;
		symbol_in   <= sym;
		address_in  <= addr;
		entry_index <= idx;
		// in_ready only moves on a rising edge, so its value here holds at the next one
		while (!in_ready)
			@(negedge clk);
		@(negedge clk);
	endtask

	// receiver: decides on the rising edge, drives on the falling edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end else begin
				@(negedge clk);
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int          n;
		int          pick;
		logic [2:0]  act;
		logic [63:0] key;
		logic [63:0] nlab;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = stc_pkg::ACT_INSERT;
		key_label   = '0;
		new_label   = '0;
		symbol_in   = '0;
		address_in  = '0;
		entry_index = '0;
		label_pool[0] = '0;
		label_pool[1] = '1;
		label_pool[2] = "LOOP";
		label_pool[3] = "START";
		for (n = 4; n < POOL_SIZE; n++)
			label_pool[n] = rand_word();
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table
		offer_request(stc_pkg::ACT_READ, '0, '0, '0, '0, 5'd0);
		offer_request(stc_pkg::ACT_READ, '0, '0, '0, '0, 5'd31);
		offer_request(stc_pkg::ACT_SEARCH, '0, '0, '0, '0, 5'd0);
		offer_request(stc_pkg::ACT_MOD_BOTH, '0, '1, '0, 16'hffff, 5'd0);
		// extremes of label, symbol and address, then a duplicate
		offer_request(stc_pkg::ACT_INSERT, '0, '0, '0, 16'h0000, 5'd0);
		offer_request(stc_pkg::ACT_INSERT, '1, '0, '1, 16'hffff, 5'd0);
		offer_request(stc_pkg::ACT_INSERT, '1, '1, 64'h1, 16'h0001, 5'd0);
		offer_request(stc_pkg::ACT_INSERT, "LOOP", '0, "MOV", 16'h0100, 5'd0);
		offer_request(stc_pkg::ACT_SEARCH, '1, '0, '0, '0, 5'd0);
		offer_request(stc_pkg::ACT_SEARCH, "NOPE", '0, '0, '0, 5'd0);
		offer_request(stc_pkg::ACT_MOD_LABEL, '0, "START", '0, 16'h5555, 5'd0);
		offer_request(stc_pkg::ACT_MOD_ADDR, "START", '1, '0, 16'h1234, 5'd0);
		// rename onto an existing label, then one modify hits both entries
		offer_request(stc_pkg::ACT_MOD_BOTH, "LOOP", "START", '0, 16'h00ff, 5'd0);
		offer_request(stc_pkg::ACT_MOD_ADDR, "START", '0, '0, 16'hbeef, 5'd0);
		offer_request(stc_pkg::ACT_MOD_LABEL, "NOPE", "LOOP", '0, '0, 5'd0);
		offer_request(stc_pkg::ACT_INSERT, "START", '0, "DUP", 16'haaaa, 5'd0);
		offer_request(stc_pkg::ACT_READ, '1, '1, '1, '1, 5'd0);
		offer_request(stc_pkg::ACT_READ, '0, '0, '0, '0, 5'd2);
		offer_request(stc_pkg::ACT_READ, '0, '0, '0, '0, 5'd3);
		offer_request(stc_pkg::ACT_READ, '0, '0, '0, '0, 5'd31);
		offer_request(ACT_SPARE_LO, '1, '1, '1, '1, 5'd31);
		offer_request(ACT_SPARE_HI, "START", '0, '0, '0, 5'd1);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				send_idle_pct = 69;
				recv_idle_pct = 19;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// long receiver hold-off while the sender keeps offering
			if (n == 120)
				hold_request = 1'b1;
			pick = $urandom_range(99);
			if (pick < 22)
				act = stc_pkg::ACT_INSERT;
			else if (pick < 40)
				act = stc_pkg::ACT_SEARCH;
			else if (pick < 52)
				act = stc_pkg::ACT_MOD_LABEL;
			else if (pick < 64)
				act = stc_pkg::ACT_MOD_ADDR;
			else if (pick < 76)
				act = stc_pkg::ACT_MOD_BOTH;
			else if (pick < 96)
				act = stc_pkg::ACT_READ;
			else
				act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
			// labels mostly from the pool so that hits and duplicates are frequent
			key  = ($urandom_range(9) < 8) ? label_pool[$urandom_range(POOL_SIZE - 1)]
				: rand_word();
			nlab = ($urandom_range(9) < 8) ? label_pool[$urandom_range(POOL_SIZE - 1)]
				: rand_word();
			offer_request(act, key, nlab, rand_word(), 16'($urandom),
				5'($urandom_range(31)));
		end
		in_valid <= 1'b0;

		while (replies_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (mismatch_count == 0 && replies_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
